// File: design/sorted_priority_queue_macros.svh
// Assertion macros shared by the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication whose consequent must hold in the cycle after the condition, outside reset.
`define SPQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: design/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Queue geometry
  localparam int DEPTH  = 16;
  localparam int VAL_W  = 32;
  localparam int RANK_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 5;

  // Action codes on the input tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // One stored entry
  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic signed [RANK_W-1:0] rank;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/spq_cell.sv
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire        clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  input  wire        left_shift,
  input  entry_t     right_entry,
  input  wire        occupied,
  output entry_t     entry,
  output logic       shift
);

  // Mark entries that must move one place toward the tail on insert
  assign shift = occupied && (entry.rank >= new_entry.rank);

  // Shift in from the left, take the new entry, or pop from the right
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_shift) begin
        entry <= left_entry;
      end else if (shift || !occupied) begin
        entry <= new_entry;
      end
    end else if (ctrl.remove) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

// File: design/sorted_priority_queue.sv
// Channel  Dir  Fields (tdata / tuser, low bit first)
// s_       in   tdata: item_value[31:0], item_rank[63:32]; tuser: action
// m_       out  tdata: status[1:0], removed_value[33:2], occupancy[38:34], zero pad
//
// Every cell compares its rank with the new one in parallel and shifts toward
// its neighbor in the same edge.
// A result sits in the output register; a new item is taken whenever that
// register is empty or is being drained, so one item per cycle is sustained.
// A stall on m_ holds the result and drops s_tready.
// Reset clears the fill count and output valid; cell contents stay undefined.
`default_nettype none
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // item_value[31:0], item_rank[63:32]
  input  wire  [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata    // status[1:0], removed_value[33:2], occupancy[38:34]
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             s_fire;
  logic             is_remove;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           entries [DEPTH];
  logic             shifts  [DEPTH];
  status_t          status;
  logic [VAL_W-1:0] removed_value;

  // Input handshake
  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign is_remove = (s_tuser[0] == ACT_REMOVE);
  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);

  assign new_entry.value = s_tdata[31:0];
  assign new_entry.rank  = s_tdata[63:32];

  // Decode the command for the cell row
  assign ctrl.insert = s_fire && !is_remove && !full;
  assign ctrl.remove = s_fire && is_remove && !empty;

  // Build the row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_e;
    logic   left_s;
    entry_t right_e;
    if (g == 0) begin : g_head
      assign left_e = new_entry;
      assign left_s = 1'b0;
    end else begin : g_body
      assign left_e = entries[g-1];
      assign left_s = shifts[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_e = entries[g];
    end else begin : g_mid
      assign right_e = entries[g+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_shift  (left_s),
      .right_entry (right_e),
      .occupied    (count > CNT_W'(g)),
      .entry       (entries[g]),
      .shift       (shifts[g])
    );
  end

  // Work out the result and the next fill count
  always_comb begin
    count_next    = count;
    removed_value = '0;
    if (is_remove) begin
      if (empty) begin
        status = ST_UNDERFLOW;
      end else begin
        status        = ST_REMOVED;
        removed_value = entries[0].value;
        count_next    = count - CNT_W'(1);
      end
    end else begin
      if (full) begin
        status = ST_OVERFLOW;
      end else begin
        status     = ST_INSERTED;
        count_next = count + CNT_W'(1);
      end
    end
  end

  // Advance the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s_fire) begin
      count <= count_next;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata[1:0]   <= status;
      m_tdata[33:2]  <= removed_value;
      m_tdata[38:34] <= OCC_W'(count_next);
      m_tdata[39]    <= 1'b0;
    end
  end

  // Fill count stays within the row
  `SPQ_ASSERT(a_count_range, count <= FULL_CNT, "fill count exceeds depth")
  // Head pair stays in rank order
  `SPQ_ASSERT(a_head_sorted, (count < CNT_W'(2)) || (entries[1].rank >= entries[0].rank),
              "head entries out of rank order")
  // A successful insert grows the queue by one
  `SPQ_ASSERT_NEXT(a_insert_grow, ctrl.insert, count == $past(count) + CNT_W'(1),
                   "insert did not grow fill count")
  // A successful remove shrinks the queue by one
  `SPQ_ASSERT_NEXT(a_remove_shrink, ctrl.remove, count == $past(count) - CNT_W'(1),
                   "remove did not shrink fill count")

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  // One result as it leaves the queue
  typedef struct packed {
    status_t     st;
    logic [31:0] removed;
    logic [4:0]  occ;
  } queue_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // item_value[31:0], item_rank[63:32]
  logic [0:0]  s_tuser;   // action
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // status[1:0], removed_value[33:2], occupancy[38:34]

  // Shadow copy of the sorted entries
  logic signed [31:0] pq_value [DEPTH];
  logic signed [31:0] pq_rank  [DEPTH];
  int                 pq_fill;

  queue_result_t pending_results[$];
  int            fail_count;

  // Idle knobs shared by the sender and the receiver
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_req;
  int rx_hold_left;
  int rx_stall_left;

  sorted_priority_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  // Mix of clustered ranks (ties), extremes and full-range values
  function automatic logic [31:0] draw_rank();
    case ($urandom_range(3))
      0: return 32'($urandom_range(8)) - 32'd4;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Apply one accepted transaction to the shadow queue and return its result
  function automatic queue_result_t queue_step_result(input logic act,
                                                      input logic signed [31:0] val,
                                                      input logic signed [31:0] rnk);
    queue_result_t r;
    int            pos;
    int            i;
    r.removed = '0;
    if (act == ACT_INSERT) begin
      if (pq_fill >= DEPTH) begin
        r.st = ST_OVERFLOW;
      end else begin
        // New entry goes ahead of the first entry with rank >= its own
        pos = 0;
        while (pos < pq_fill && pq_rank[pos] < rnk) pos++;
        for (i = pq_fill; i > pos; i--) begin
          pq_value[i] = pq_value[i-1];
          pq_rank[i]  = pq_rank[i-1];
        end
        pq_value[pos] = val;
        pq_rank[pos]  = rnk;
        pq_fill++;
        r.st = ST_INSERTED;
      end
    end else begin
      if (pq_fill == 0) begin
        r.st = ST_UNDERFLOW;
      end else begin
        r.removed = pq_value[0];
        for (i = 1; i < pq_fill; i++) begin
          pq_value[i-1] = pq_value[i];
          pq_rank[i-1]  = pq_rank[i];
        end
        pq_fill--;
        r.st = ST_REMOVED;
      end
    end
    r.occ = 5'(pq_fill);
    return r;
  endfunction

  // Offer one item, hold it until the transaction completes, then predict
  task automatic send_item(input logic act, input logic [31:0] val, input logic [31:0] rnk);
    int gap;
    gap = draw_gap(tx_idle_pct);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rnk, val};
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(queue_step_result(act, val, rnk));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver: check each transaction, then pick next tready
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with no pending expectation: tdata %h", m_tdata);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (m_tdata[1:0] !== exp_r.st) begin
            $error("status: expected %0d, got %0d", exp_r.st, m_tdata[1:0]);
            fail_count++;
          end
          if (m_tdata[33:2] !== exp_r.removed) begin
            $error("removed_value: expected %h, got %h", exp_r.removed, m_tdata[33:2]);
            fail_count++;
          end
          if (m_tdata[38:34] !== exp_r.occ) begin
            $error("occupancy: expected %0d, got %0d", exp_r.occ, m_tdata[38:34]);
            fail_count++;
          end
        end
      end
      // Long hold-off requested by a test takes priority over random stalls
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left > 0) begin
        m_tready <= 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        m_tready <= 1'b0;
        rx_stall_left--;
      end else begin
        m_tready <= 1'b1;
        rx_stall_left = draw_gap(rx_idle_pct);
      end
    end
  end

  // Remove from empty, with every input bit set and clear
  task automatic test_underflow();
    send_item(ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  // Ties at head, middle and tail; rank and value extremes
  task automatic test_ties_and_extremes();
    send_item(ACT_INSERT, 32'h0000_0001, 32'h0000_0000);
    send_item(ACT_INSERT, 32'h0000_0002, 32'h0000_0000);
    send_item(ACT_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(ACT_INSERT, 32'h8000_0000, 32'h8000_0000);
    send_item(ACT_INSERT, 32'hffff_ffff, 32'h0000_0000);
    send_item(ACT_INSERT, 32'h0000_0000, 32'h7fff_ffff);
    send_item(ACT_INSERT, 32'h5555_5555, 32'hffff_ffff);
    send_item(ACT_INSERT, 32'haaaa_aaaa, 32'h0000_0001);
    repeat (9) send_item(ACT_REMOVE, $urandom, $urandom);
  endtask

  // Fill to capacity, push past it, then pop past empty
  task automatic test_fill_overflow();
    while (pq_fill < DEPTH) send_item(ACT_INSERT, $urandom, draw_rank());
    repeat (2) send_item(ACT_INSERT, $urandom, draw_rank());
    while (pq_fill > 0) send_item(ACT_REMOVE, $urandom, $urandom);
    send_item(ACT_REMOVE, $urandom, $urandom);
  endtask

  // Hold the output off while the sender keeps offering, then drain
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_hold_req = 80;
    repeat (40) send_item(($urandom_range(99) < 70) ? ACT_INSERT : ACT_REMOVE,
                          $urandom, draw_rank());
    wait_drained();
  endtask

  // Bursts biased toward insert or remove so occupancy sweeps the whole range
  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    int ins_pct;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(60, 10);
      case ($urandom_range(2))
        0: ins_pct = 25;
        1: ins_pct = 50;
        default: ins_pct = 75;
      endcase
      case ($urandom_range(3))
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 10; rx_idle_pct = 30; end
        2: begin tx_idle_pct = 30; rx_idle_pct = 10; end
        default: begin tx_idle_pct = 30; rx_idle_pct = 30; end
      endcase
      repeat (burst) begin
        send_item(($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_REMOVE,
                  $urandom, draw_rank());
        sent++;
      end
    end
  endtask

  // Stimulus sequence and final verdict
  initial begin
    int n;
    fail_count    = 0;
    tx_idle_pct   = 20;
    rx_idle_pct   = 20;
    rx_hold_req   = 0;
    rx_hold_left  = 0;
    rx_stall_left = 0;
    pq_fill       = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_underflow();
    test_ties_and_extremes();
    test_fill_overflow();
    test_backpressure();
    test_random_traffic(2000);

    // Let outstanding results arrive, then watch for stray ones
    s_tvalid <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (pending_results.size() != 0 && n < 10000);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    repeat (5) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/tb.sv
